// ===== hdl/bmc_pkg.sv =====
package bmc_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [3:0] PWM_STEPS = 4'd10;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_PERIODS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_DUTY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MODE_ZERO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MODE_ONE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MODE_TWO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MODE_THREE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_CODES = 3'd7;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_SWITCH = 2'd1;
  localparam logic [1:0] KIND_ECHO = 2'd2;

  localparam logic [1:0] MODE_HAZE = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [7:0] RST_HOLD_PERIODS = 8'd200;
  localparam logic [15:0] RST_SILENCE_LIMIT = 16'd1000;
  localparam logic [3:0] RST_SWITCH_DUTY = 4'd10;
  localparam logic [3:0] RST_DUTY_MODE_ZERO = 4'd0;
  localparam logic [3:0] RST_DUTY_MODE_OTHER = 4'd3;
  localparam logic [15:0] RST_PANEL_CODES = 16'hFC60;

  typedef struct packed {
    logic [7:0]       hold_periods;
    logic [15:0]      silence_limit;
    logic [3:0]       switch_duty;
    logic [3:0][3:0]  mode_duty;
    logic [15:0]      panel_codes;
  } cfg_t;

  // All results caused by one tick; the status result is always present
  typedef struct packed {
    logic       echo_v;
    logic [7:0] echo_byte;
    logic       pwm_level;
    logic       sw1_v;
    logic [1:0] sw1_mode;
    logic [3:0] sw1_code;
    logic       sw2_v;
    logic [3:0] sw2_code;
  } bundle_t;

endpackage

// ===== hdl/backlight_pwm_mode_controller_top.sv =====
// Backlight PWM mode controller.
// Input channel (in_valid/in_ready): one request per timer tick carrying the
// two active-low buttons and an optional received serial byte.
// Result channel (out_valid/out_ready): one to four results per tick, in the
// order echo, status, button switch, timeout switch; out_last marks the final
// result of a tick.
// Configuration: cfg_we writes cfg_wdata into register cfg_index.
// The first result of a tick is valid in the cycle after the tick is taken.
// Throughput: one tick per cycle while each tick gives a single result and
// the receiver does not stall; a tick with more results holds the result
// register until its last result is delivered, when the next tick is taken.
// Reset: registers take their default values and the block starts in the
// hold after a switch to mode 3, with no result issued for it.
// When the receiver stalls, pending results hold and in_ready drops until
// the final result of the current tick is taken.
module backlight_pwm_mode_controller_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_haze_button_n,
  input  logic                            in_clear_button_n,
  input  logic                            in_rx_valid,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_kind,
  output logic                            out_pwm_level,
  output logic [1:0]                      out_new_mode,
  output logic [3:0]                      out_panel_code,
  output logic [7:0]                      out_echo_byte,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [bmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bmc_pkg::*;

  cfg_t    cfg;
  bundle_t bundle;
  logic    can_load;
  logic    tick;

  assign in_ready = can_load;
  assign tick = in_valid & can_load;

  bmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bmc_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .tick           (tick),
    .haze_button_n  (in_haze_button_n),
    .clear_button_n (in_clear_button_n),
    .rx_valid       (in_rx_valid),
    .rx_byte        (in_rx_byte),
    .bundle         (bundle)
  );

  bmc_ser u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (tick),
    .bundle         (bundle),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_pwm_level  (out_pwm_level),
    .out_new_mode   (out_new_mode),
    .out_panel_code (out_panel_code),
    .out_echo_byte  (out_echo_byte),
    .out_last       (out_last)
  );

endmodule

// ===== hdl/bmc_cfg.sv =====
module bmc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output bmc_pkg::cfg_t                   cfg
);
  import bmc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_periods <= RST_HOLD_PERIODS;
      cfg_r.silence_limit <= RST_SILENCE_LIMIT;
      cfg_r.switch_duty <= RST_SWITCH_DUTY;
      cfg_r.mode_duty[0] <= RST_DUTY_MODE_ZERO;
      cfg_r.mode_duty[1] <= RST_DUTY_MODE_OTHER;
      cfg_r.mode_duty[2] <= RST_DUTY_MODE_OTHER;
      cfg_r.mode_duty[3] <= RST_DUTY_MODE_OTHER;
      cfg_r.panel_codes <= RST_PANEL_CODES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOLD_PERIODS:    cfg_r.hold_periods <= cfg_wdata[7:0];
        REG_SILENCE_LIMIT:   cfg_r.silence_limit <= cfg_wdata;
        REG_SWITCH_DUTY:     cfg_r.switch_duty <= cfg_wdata[3:0];
        REG_DUTY_MODE_ZERO:  cfg_r.mode_duty[0] <= cfg_wdata[3:0];
        REG_DUTY_MODE_ONE:   cfg_r.mode_duty[1] <= cfg_wdata[3:0];
        REG_DUTY_MODE_TWO:   cfg_r.mode_duty[2] <= cfg_wdata[3:0];
        REG_DUTY_MODE_THREE: cfg_r.mode_duty[3] <= cfg_wdata[3:0];
        REG_PANEL_CODES:     cfg_r.panel_codes <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/bmc_core.sv =====
module bmc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  bmc_pkg::cfg_t     cfg,
  input  logic              tick,
  input  logic              haze_button_n,
  input  logic              clear_button_n,
  input  logic              rx_valid,
  input  logic [7:0]        rx_byte,
  output bmc_pkg::bundle_t  bundle
);
  import bmc_pkg::*;

  logic [3:0]  pwm_count_r, pwm_count_nxt;
  logic [7:0]  period_count_r, period_count_nxt;
  logic [3:0]  duty_now_r, duty_now_nxt;
  logic        switching_r, switching_nxt;
  logic [1:0]  mode_now_r, mode_now_nxt;
  logic [15:0] silence_count_r, silence_count_nxt;
  logic        link_seen_r, link_seen_nxt;
  logic [3:0]  pwm_inc;

  always_comb begin
    pwm_inc = pwm_count_r + 4'd1;
    pwm_count_nxt = pwm_inc;
    period_count_nxt = period_count_r;
    duty_now_nxt = duty_now_r;
    switching_nxt = switching_r;
    mode_now_nxt = mode_now_r;
    silence_count_nxt = silence_count_r;
    link_seen_nxt = link_seen_r;
    bundle = '0;

    if (rx_valid) begin
      silence_count_nxt = '0;
      link_seen_nxt = 1'b1;
      bundle.echo_v = 1'b1;
      bundle.echo_byte = rx_byte;
    end else if (silence_count_r != 16'hFFFF) begin
      silence_count_nxt = silence_count_r + 16'd1;
    end

    if (pwm_inc >= PWM_STEPS) begin
      pwm_count_nxt = '0;
      period_count_nxt = period_count_r + 8'd1;
    end

    bundle.pwm_level = (pwm_count_nxt < duty_now_r);

    if (switching_r) begin
      // end the hold and load the duty of the current mode
      if (period_count_nxt > cfg.hold_periods) begin
        switching_nxt = 1'b0;
        duty_now_nxt = cfg.mode_duty[mode_now_r];
      end
    end else if (!haze_button_n || !clear_button_n) begin
      bundle.sw1_v = 1'b1;
      bundle.sw1_mode = !haze_button_n ? MODE_HAZE : MODE_CLEAR;
      bundle.sw1_code = !haze_button_n ? cfg.panel_codes[3:0] : cfg.panel_codes[15:12];
      switching_nxt = 1'b1;
      period_count_nxt = '0;
      duty_now_nxt = cfg.switch_duty;
      mode_now_nxt = bundle.sw1_mode;
    end

    // link timeout forces clear mode and restarts any hold
    if (silence_count_nxt > cfg.silence_limit && link_seen_nxt) begin
      bundle.sw2_v = 1'b1;
      bundle.sw2_code = cfg.panel_codes[15:12];
      switching_nxt = 1'b1;
      period_count_nxt = '0;
      duty_now_nxt = cfg.switch_duty;
      mode_now_nxt = MODE_CLEAR;
      link_seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_count_r <= '0;
      period_count_r <= '0;
      duty_now_r <= RST_SWITCH_DUTY;
      switching_r <= 1'b1;
      mode_now_r <= MODE_CLEAR;
      silence_count_r <= '0;
      link_seen_r <= 1'b0;
    end else if (tick) begin
      pwm_count_r <= pwm_count_nxt;
      period_count_r <= period_count_nxt;
      duty_now_r <= duty_now_nxt;
      switching_r <= switching_nxt;
      mode_now_r <= mode_now_nxt;
      silence_count_r <= silence_count_nxt;
      link_seen_r <= link_seen_nxt;
    end
  end

endmodule

// ===== hdl/bmc_ser.sv =====
module bmc_ser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  bmc_pkg::bundle_t  bundle,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic              out_pwm_level,
  output logic [1:0]        out_new_mode,
  output logic [3:0]        out_panel_code,
  output logic [7:0]        out_echo_byte,
  output logic              out_last
);
  import bmc_pkg::*;

  bundle_t    res_r;
  logic       echo_p_r, stat_p_r, sw1_p_r, sw2_p_r;
  logic       take;

  assign out_valid = echo_p_r | stat_p_r | sw1_p_r | sw2_p_r;
  assign out_last = ($countones({echo_p_r, stat_p_r, sw1_p_r, sw2_p_r}) == 1);
  assign take = out_valid & out_ready;
  assign can_load = !out_valid || (out_ready && out_last);

  always_comb begin
    out_kind = KIND_STATUS;
    out_pwm_level = 1'b0;
    out_new_mode = '0;
    out_panel_code = '0;
    out_echo_byte = '0;
    if (echo_p_r) begin
      out_kind = KIND_ECHO;
      out_echo_byte = res_r.echo_byte;
    end else if (stat_p_r) begin
      out_pwm_level = res_r.pwm_level;
    end else if (sw1_p_r) begin
      out_kind = KIND_SWITCH;
      out_new_mode = res_r.sw1_mode;
      out_panel_code = res_r.sw1_code;
    end else if (sw2_p_r) begin
      out_kind = KIND_SWITCH;
      out_new_mode = MODE_CLEAR;
      out_panel_code = res_r.sw2_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_p_r <= 1'b0;
      stat_p_r <= 1'b0;
      sw1_p_r <= 1'b0;
      sw2_p_r <= 1'b0;
    end else if (load) begin
      echo_p_r <= bundle.echo_v;
      stat_p_r <= 1'b1;
      sw1_p_r <= bundle.sw1_v;
      sw2_p_r <= bundle.sw2_v;
    end else if (take) begin
      // drop the request just delivered
      if (echo_p_r) begin
        echo_p_r <= 1'b0;
      end else if (stat_p_r) begin
        stat_p_r <= 1'b0;
      end else if (sw1_p_r) begin
        sw1_p_r <= 1'b0;
      end else begin
        sw2_p_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= bundle;
    end
  end

`ifndef SYNTH
  a_load_only_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid || (out_ready && out_last)))
    else $error("new tick loaded over undelivered results");

  a_load_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("loaded tick produced no result");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !out_last) |=> out_valid)
    else $error("results lost before last");

  a_status_before_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_SWITCH) |-> !stat_p_r && !echo_p_r)
    else $error("switch result ahead of status");
`endif

endmodule

// ===== tb/backlight_pwm_mode_controller_top_test.sv =====
`timescale 1ns / 1ps

module backlight_pwm_mode_controller_top_test;
  import bmc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic       haze_n;
    logic       clear_n;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } tick_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       pwm_level;
    logic [1:0] new_mode;
    logic [3:0] panel_code;
    logic [7:0] echo_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic                 is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [15:0]          reg_val;
    tick_t                tick;
    logic [16:0]          reps;
    logic                 typed;
    result_t              first_res;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_haze_button_n = 1'b1;
  logic                  in_clear_button_n = 1'b1;
  logic                  in_rx_valid = 1'b0;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_kind;
  logic                  out_pwm_level;
  logic [1:0]            out_new_mode;
  logic [3:0]            out_panel_code;
  logic [7:0]            out_echo_byte;
  logic                  out_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  backlight_pwm_mode_controller_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_haze_button_n  (in_haze_button_n),
    .in_clear_button_n (in_clear_button_n),
    .in_rx_valid       (in_rx_valid),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_pwm_level     (out_pwm_level),
    .out_new_mode      (out_new_mode),
    .out_panel_code    (out_panel_code),
    .out_echo_byte     (out_echo_byte),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block: registers and controller state
  cfg_t        shadow_regs = '{hold_periods: RST_HOLD_PERIODS,
                               silence_limit: RST_SILENCE_LIMIT,
                               switch_duty: RST_SWITCH_DUTY,
                               mode_duty: {RST_DUTY_MODE_OTHER, RST_DUTY_MODE_OTHER,
                                           RST_DUTY_MODE_OTHER, RST_DUTY_MODE_ZERO},
                               panel_codes: RST_PANEL_CODES};
  logic [3:0]  pwm_step = 4'd0;
  logic [7:0]  periods_done = 8'd0;
  logic [3:0]  duty_cur = RST_SWITCH_DUTY;
  logic        holding = 1'b1;
  logic [1:0]  mode_cur = MODE_CLEAR;
  logic [15:0] quiet_ticks = 16'd0;
  logic        link_up = 1'b0;

  result_t     tick_out [4];
  int          n_out;
  result_t     due_results [$];
  int          err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_off_tog = 1'b0;
  logic        hold_off_seen = 1'b0;
  int unsigned hold_off_left = 0;
  step_t       script [$];

  function automatic result_t mk_result(logic [1:0] kind, logic lvl, logic [1:0] mode,
                                        logic [3:0] code, logic [7:0] echo, logic last);
    result_t r;
    r.kind = kind;
    r.pwm_level = lvl;
    r.new_mode = mode;
    r.panel_code = code;
    r.echo_byte = echo;
    r.last = last;
    return r;
  endfunction

  function automatic void switch_to(logic [1:0] m);
    holding = 1'b1;
    periods_done = 8'd0;
    duty_cur = shadow_regs.switch_duty;
    mode_cur = m;
    tick_out[n_out] = mk_result(KIND_SWITCH, 1'b0, m, shadow_regs.panel_codes[{m, 2'b00} +: 4],
                                8'h00, 1'b0);
    n_out++;
  endfunction

  task automatic predict_tick(input tick_t t, input logic typed, input result_t first_res);
    n_out = 0;
    if (t.rx_valid) begin
      quiet_ticks = 16'd0;
      link_up = 1'b1;
      tick_out[n_out] = mk_result(KIND_ECHO, 1'b0, 2'd0, 4'd0, t.rx_byte, 1'b0);
      n_out++;
    end else if (quiet_ticks != 16'hFFFF) begin
      quiet_ticks++;
    end
    pwm_step = pwm_step + 4'd1;
    if (pwm_step >= PWM_STEPS) begin
      pwm_step = 4'd0;
      periods_done = periods_done + 8'd1;
    end
    tick_out[n_out] = mk_result(KIND_STATUS, pwm_step < duty_cur, 2'd0, 4'd0, 8'h00, 1'b0);
    n_out++;
    if (holding) begin
      if (periods_done > shadow_regs.hold_periods) begin
        holding = 1'b0;
        duty_cur = shadow_regs.mode_duty[mode_cur];
      end
    end else if (!t.haze_n) begin
      switch_to(MODE_HAZE);
    end else if (!t.clear_n) begin
      switch_to(MODE_CLEAR);
    end
    if (quiet_ticks > shadow_regs.silence_limit && link_up) begin
      switch_to(MODE_CLEAR);
      link_up = 1'b0;
    end
    tick_out[n_out-1].last = 1'b1;
    if (typed) tick_out[0] = first_res;
    for (int i = 0; i < n_out; i++) due_results.push_back(tick_out[i]);
  endtask

  // Drop valid, wait for every due result, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    if (!cfg_we) settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx) inside
      REG_HOLD_PERIODS:  shadow_regs.hold_periods = val[7:0];
      REG_SILENCE_LIMIT: shadow_regs.silence_limit = val;
      REG_SWITCH_DUTY:   shadow_regs.switch_duty = val[3:0];
      REG_DUTY_MODE_ZERO, REG_DUTY_MODE_ONE, REG_DUTY_MODE_TWO, REG_DUTY_MODE_THREE:
        shadow_regs.mode_duty[2'(idx - REG_DUTY_MODE_ZERO)] = val[3:0];
      REG_PANEL_CODES:   shadow_regs.panel_codes = val;
      default: ;
    endcase
  endtask

  task automatic send_tick(input tick_t t, input logic typed, input result_t first_res);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_haze_button_n <= t.haze_n;
    in_clear_button_n <= t.clear_n;
    in_rx_valid <= t.rx_valid;
    in_rx_byte <= t.rx_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(t, typed, first_res);
  endtask

  task automatic pace(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
  endtask

  task automatic random_config(input int p);
    set_reg(REG_HOLD_PERIODS, (p == 3) ? 16'd255 : 16'($urandom_range(2)));
    set_reg(REG_SILENCE_LIMIT, (p == 1) ? 16'd0 : (p == 2) ? 16'hFFFF :
                               16'($urandom_range(1, 12)));
    set_reg(REG_SWITCH_DUTY, (p == 0) ? 16'd0 : (p == 1) ? 16'd10 :
                             16'($urandom_range(15)));
    for (int i = 0; i < 4; i++)
      set_reg(CFG_IDX_W'(REG_DUTY_MODE_ZERO + i), 16'($urandom_range(15)));
    set_reg(REG_PANEL_CODES, 16'($urandom));
  endtask

  function automatic step_t on_tick(logic haze_n, logic clear_n, logic rxv,
                                    logic [7:0] rxb, int reps);
    step_t s;
    s = '0;
    s.tick.haze_n = haze_n;
    s.tick.clear_n = clear_n;
    s.tick.rx_valid = rxv;
    s.tick.rx_byte = rxb;
    s.reps = 17'(reps);
    return s;
  endfunction

  function automatic step_t on_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    step_t s;
    s = '0;
    s.is_write = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_t checked(step_t s, result_t r);
    s.typed = 1'b1;
    s.first_res = r;
    return s;
  endfunction

  function automatic tick_t random_tick(int unsigned rx_pct);
    tick_t t;
    t.haze_n = $urandom_range(99) >= 25;
    t.clear_n = $urandom_range(99) >= 30;
    t.rx_valid = $urandom_range(99) < rx_pct;
    t.rx_byte = 8'($urandom_range(255));
    return t;
  endfunction

  // Receiver: random stalls, or a long hold-off when the toggle flips
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_tog != hold_off_seen) begin
      hold_off_seen <= hold_off_tog;
      hold_off_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= rx_stall_pct;
    end
  end

  always @(posedge clk) begin : check_result
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        if (err_count < 10)
          $display("unexpected result: kind=%0d lvl=%0d mode=%0d code=%0h echo=%0h last=%0d",
                   out_kind, out_pwm_level, out_new_mode, out_panel_code, out_echo_byte,
                   out_last);
        err_count++;
      end else begin
        want = due_results.pop_front();
        if (out_kind !== want.kind || out_pwm_level !== want.pwm_level ||
            out_new_mode !== want.new_mode || out_panel_code !== want.panel_code ||
            out_echo_byte !== want.echo_byte || out_last !== want.last) begin
          if (err_count < 10)
            $display("mismatch: expected kind=%0d lvl=%0d mode=%0d code=%0h echo=%0h last=%0d",
                     want.kind, want.pwm_level, want.new_mode, want.panel_code,
                     want.echo_byte, want.last,
                     "; got kind=%0d lvl=%0d mode=%0d code=%0h echo=%0h last=%0d",
                     out_kind, out_pwm_level, out_new_mode, out_panel_code,
                     out_echo_byte, out_last);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : main_flow
    // Start-up hold at full switching duty; buttons are ignored there
    script.push_back(checked(on_tick(1'b1, 1'b1, 1'b0, 8'h00, 1),
                             mk_result(KIND_STATUS, 1'b1, 2'd0, 4'd0, 8'h00, 1'b1)));
    script.push_back(checked(on_tick(1'b0, 1'b0, 1'b1, 8'hFF, 1),
                             mk_result(KIND_ECHO, 1'b0, 2'd0, 4'd0, 8'hFF, 1'b0)));
    script.push_back(checked(on_tick(1'b1, 1'b1, 1'b1, 8'h00, 1),
                             mk_result(KIND_ECHO, 1'b0, 2'd0, 4'd0, 8'h00, 1'b0)));
    script.push_back(on_write(REG_HOLD_PERIODS, 16'd0));
    script.push_back(on_write(REG_SILENCE_LIMIT, 16'hFFFF));
    // Loaded duty stays; only later switches pick this up
    script.push_back(on_write(REG_SWITCH_DUTY, 16'd15));
    script.push_back(on_write(REG_DUTY_MODE_ZERO, 16'd10));
    script.push_back(on_write(REG_DUTY_MODE_ONE, 16'd0));
    script.push_back(on_write(REG_DUTY_MODE_TWO, 16'd5));
    script.push_back(on_write(REG_DUTY_MODE_THREE, 16'd11));
    script.push_back(on_write(REG_PANEL_CODES, 16'hA5C3));
    // Hold runs out, then haze takes effect without clearing the PWM counter
    script.push_back(on_tick(1'b0, 1'b1, 1'b1, 8'h5A, 8));
    script.push_back(on_write(REG_SILENCE_LIMIT, 16'd0));
    script.push_back(on_tick(1'b1, 1'b1, 1'b1, 8'h81, 9));
    // Button switch and timeout switch in the same tick
    script.push_back(on_tick(1'b0, 1'b1, 1'b0, 8'h00, 1));
    script.push_back(on_tick(1'b1, 1'b0, 1'b1, 8'h3C, 11));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    pace(0, 0);

    foreach (script[i]) begin
      if (script[i].is_write) begin
        set_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        repeat (script[i].reps) send_tick(script[i].tick, script[i].typed,
                                          script[i].first_res);
      end
    end

    for (int p = 0; p < 5; p++) begin
      int unsigned rx_pct;
      random_config(p);
      rx_pct = $urandom_range(15, 70);
      case (p)
        0: pace(0, 0);
        1: pace(50, 0);
        2: pace(0, 50);
        3: pace(28, 28);
        default: begin
          pace(0, 0);
          hold_off_tog <= ~hold_off_tog;
        end
      endcase
      repeat (26) send_tick(random_tick(rx_pct), 1'b0, '0);
    end

    settle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
